### rtl/core/lerm_pkg.sv
// ----------------------------------------------------------------------------
// Euler rotation matrix package
// Types, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lerm_pkg;

  localparam int ANGLE_WIDTH  = 16;
  localparam int COEFF_WIDTH  = 16;
  localparam int QW           = 36;
  localparam int FRAC_BITS    = 30;
  localparam int CORDIC_STEPS = 32;
  localparam int NUM_REGS     = 6;
  localparam int IDX_WIDTH    = 3;

  localparam logic signed [QW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [QW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [QW-1:0] INV_GAIN    = 36'sh026DD3B6A;

  localparam logic [IDX_WIDTH-1:0] REG_X_MIN = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_X_MAX = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_Y_MIN = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_Y_MAX = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_Z_MIN = 3'd4;
  localparam logic [IDX_WIDTH-1:0] REG_Z_MAX = 3'd5;

  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef logic signed [COEFF_WIDTH-1:0] coeff_t;
  typedef logic signed [QW-1:0]          q30_t;

  typedef struct packed {
    angle_t pose_x;
    angle_t pose_y;
    angle_t pose_z;
  } pose_t;

  typedef struct packed {
    coeff_t m_row0_col0;
    coeff_t m_row0_col1;
    coeff_t m_row0_col2;
    coeff_t m_row1_col0;
    coeff_t m_row1_col1;
    coeff_t m_row1_col2;
    coeff_t m_row2_col0;
    coeff_t m_row2_col1;
    coeff_t m_row2_col2;
  } matrix_t;

  function automatic q30_t atan_tab(input int i);
    case (i)
      0: atan_tab = 36'sh03243F6A8;
      1: atan_tab = 36'sh01DAC6705;
      2: atan_tab = 36'sh00FADBAFC;
      3: atan_tab = 36'sh007F56EA6;
      4: atan_tab = 36'sh003FEAB76;
      5: atan_tab = 36'sh001FFD55B;
      6: atan_tab = 36'sh000FFFAAA;
      7: atan_tab = 36'sh0007FFF55;
      8: atan_tab = 36'sh0003FFFEA;
      9: atan_tab = 36'sh0001FFFFD;
      10: atan_tab = 36'sh0000FFFFF;
      11: atan_tab = 36'sh00007FFFF;
      12: atan_tab = 36'sh00003FFFF;
      13: atan_tab = 36'sh00001FFFF;
      14: atan_tab = 36'sh00000FFFF;
      15: atan_tab = 36'sh000007FFF;
      16: atan_tab = 36'sh000003FFF;
      17: atan_tab = 36'sh000001FFF;
      18: atan_tab = 36'sh000000FFF;
      19: atan_tab = 36'sh0000007FF;
      20: atan_tab = 36'sh0000003FF;
      21: atan_tab = 36'sh0000001FF;
      22: atan_tab = 36'sh0000000FF;
      23: atan_tab = 36'sh00000007F;
      24: atan_tab = 36'sh00000003F;
      25: atan_tab = 36'sh00000001F;
      26: atan_tab = 36'sh00000000F;
      27: atan_tab = 36'sh000000008;
      28: atan_tab = 36'sh000000004;
      29: atan_tab = 36'sh000000002;
      30: atan_tab = 36'sh000000001;
      default: atan_tab = '0;
    endcase
  endfunction

endpackage

### rtl/core/lerm_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined sine and cosine
// Quadrant fold, 32 CORDIC rotation stages and sign restore, one stage each.
// ----------------------------------------------------------------------------
module lerm_cordic (
  input  logic          clk,
  input  logic          en,
  input  lerm_pkg::q30_t ang,
  output lerm_pkg::q30_t sin_o,
  output lerm_pkg::q30_t cos_o
);
  import lerm_pkg::*;

  q30_t x_r [CORDIC_STEPS+1];
  q30_t y_r [CORDIC_STEPS+1];
  q30_t z_r [CORDIC_STEPS+1];
  logic neg_r [CORDIC_STEPS+1];
  q30_t sin_r, cos_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= INV_GAIN;
      y_r[0] <= '0;
      if (ang > HALF_PI_Q30) begin
        z_r[0] <= ang - PI_Q30;
        neg_r[0] <= 1'b1;
      end else if (ang < -HALF_PI_Q30) begin
        z_r[0] <= ang + PI_Q30;
        neg_r[0] <= 1'b1;
      end else begin
        z_r[0] <= ang;
        neg_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][QW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_tab(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_tab(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= neg_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
      sin_r <= neg_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;
endmodule

### rtl/core/limited_euler_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// Limited Euler rotation matrix unit
// Clamps three angles and gives the matrix Rz*Ry*Rx in Q1.14.
// ----------------------------------------------------------------------------
//  channel  | ports                       | payload
//  request  | in_valid, in_stall, in_data | pose_t
//  result   | out_valid, out_stall, out_data | matrix_t
//  config   | cfg_we, cfg_idx, cfg_wdata  | limit registers
//
// One request per cycle unless a stalled result holds the pipeline; a result passes the
// clamp stage, the 34-stage CORDIC and the product, sum and rounding stages before it is valid.
// Reset clears the valid bits and restores the full-range limits.
// A stall at the output freezes the whole pipeline while a result is valid.
module limited_euler_rotation_matrix_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  lerm_pkg::pose_t                      in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output lerm_pkg::matrix_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [lerm_pkg::IDX_WIDTH-1:0]       cfg_idx,
  input  logic [lerm_pkg::ANGLE_WIDTH-1:0]     cfg_wdata
);
  import lerm_pkg::*;

  localparam int LAT = CORDIC_STEPS + 6;

  angle_t lim_r [NUM_REGS];
  logic [LAT-1:0] vld_r;
  logic en;
  assign en = !(out_stall && vld_r[LAT-1]);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r[0] <= {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
      lim_r[1] <= {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
      lim_r[2] <= {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
      lim_r[3] <= {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
      lim_r[4] <= {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
      lim_r[5] <= {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_X_MIN: lim_r[0] <= cfg_wdata;
        REG_X_MAX: lim_r[1] <= cfg_wdata;
        REG_Y_MIN: lim_r[2] <= cfg_wdata;
        REG_Y_MAX: lim_r[3] <= cfg_wdata;
        REG_Z_MIN: lim_r[4] <= cfg_wdata;
        REG_Z_MAX: lim_r[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
  end

  function automatic angle_t clamp(input angle_t a, input angle_t lo, input angle_t hi);
    angle_t t;
    t = (a < lo) ? lo : a;
    clamp = (t > hi) ? hi : t;
  endfunction

  // Stage 1: clamp and scale to Q2.30.
  q30_t ax_r, ay_r, az_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= q30_t'(clamp(in_data.pose_x, lim_r[0], lim_r[1])) <<< (33-ANGLE_WIDTH);
      ay_r <= q30_t'(clamp(in_data.pose_y, lim_r[2], lim_r[3])) <<< (33-ANGLE_WIDTH);
      az_r <= q30_t'(clamp(in_data.pose_z, lim_r[4], lim_r[5])) <<< (33-ANGLE_WIDTH);
    end
  end

  q30_t sx, cx, sy, cy, sz, cz;
  lerm_cordic u_cx (.clk, .en, .ang(ax_r), .sin_o(sx), .cos_o(cx));
  lerm_cordic u_cy (.clk, .en, .ang(ay_r), .sin_o(sy), .cos_o(cy));
  lerm_cordic u_cz (.clk, .en, .ang(az_r), .sin_o(sz), .cos_o(cz));

  // Every factor lies within about plus or minus one, so 32 bits hold it exactly.
  function automatic q30_t mq(input q30_t a, input q30_t b);
    logic signed [31:0] a32, b32;
    logic signed [63:0] p;
    a32 = a[31:0];
    b32 = b[31:0];
    p = a32 * b32 + (64'sd1 <<< (FRAC_BITS-1));
    mq = q30_t'(p >>> FRAC_BITS);
  endfunction

  function automatic coeff_t tc(input q30_t v);
    localparam int SH = FRAC_BITS - (COEFF_WIDTH - 2);
    q30_t r, one;
    one = q30_t'(1) <<< (COEFF_WIDTH-2);
    if (SH > 0) r = (v + (q30_t'(1) <<< (SH > 0 ? SH-1 : 0))) >>> SH;
    else r = v;
    if (r > one) r = one;
    if (r < -one) r = -one;
    tc = coeff_t'(r);
  endfunction

  // Stage A: pair products.
  q30_t czsy_r, szsy_r, czcy_r, szcy_r, cysx_r, cycx_r, szcx_r, szsx_r, czcx_r, czsx_r;
  q30_t sx_a_r, cx_a_r, sy_a_r;
  always_ff @(posedge clk) begin
    if (en) begin
      czsy_r <= mq(cz, sy); szsy_r <= mq(sz, sy);
      czcy_r <= mq(cz, cy); szcy_r <= mq(sz, cy);
      cysx_r <= mq(cy, sx); cycx_r <= mq(cy, cx);
      szcx_r <= mq(sz, cx); szsx_r <= mq(sz, sx);
      czcx_r <= mq(cz, cx); czsx_r <= mq(cz, sx);
      sx_a_r <= sx; cx_a_r <= cx; sy_a_r <= sy;
    end
  end

  // Stage B: triple products and sums.
  q30_t e_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= czcy_r;
      e_r[1] <= mq(czsy_r, sx_a_r) - szcx_r;
      e_r[2] <= mq(czsy_r, cx_a_r) + szsx_r;
      e_r[3] <= szcy_r;
      e_r[4] <= mq(szsy_r, sx_a_r) + czcx_r;
      e_r[5] <= mq(szsy_r, cx_a_r) - czsx_r;
      e_r[6] <= -sy_a_r;
      e_r[7] <= cysx_r;
      e_r[8] <= cycx_r;
    end
  end

  // Stage C: round and saturate.
  matrix_t out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.m_row0_col0 <= tc(e_r[0]);
      out_r.m_row0_col1 <= tc(e_r[1]);
      out_r.m_row0_col2 <= tc(e_r[2]);
      out_r.m_row1_col0 <= tc(e_r[3]);
      out_r.m_row1_col1 <= tc(e_r[4]);
      out_r.m_row1_col2 <= tc(e_r[5]);
      out_r.m_row2_col0 <= tc(e_r[6]);
      out_r.m_row2_col1 <= tc(e_r[7]);
      out_r.m_row2_col2 <= tc(e_r[8]);
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("stall without pending result");
  a_valid_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall && in_valid) |=> vld_r[0]) else $error("accepted request lost");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vld_r)) else $error("pipeline moved under stall");
`endif
endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// Limited Euler rotation matrix unit testbench
// Drives pose requests through the unit under several limit settings and
// idling and output-stall phases, predicts each matrix with a bit-exact CORDIC
// model and compares every whole result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lerm_pkg::*;

  localparam int LATENCY = 38;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pose_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  matrix_t out_data;
  logic cfg_we = 1'b0;
  logic [IDX_WIDTH-1:0] cfg_idx = '0;
  logic [ANGLE_WIDTH-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  limited_euler_rotation_matrix_unit dut (.*);

  angle_t limits [NUM_REGS];
  matrix_t pending_matrices [$];
  int mismatches = 0;
  int sent = 0;
  int received = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mulq(longint a, longint b);
    return shr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  task automatic sin_cos(input longint ang, output longint s, output longint c);
    longint x, y, z, xs, ys, tab;
    bit neg;
    x = 64'h26DD3B6A; y = 0; z = ang; neg = 0;
    if (z > longint'(HALF_PI_Q30)) begin
      z -= longint'(PI_Q30); neg = 1;
    end else if (z < -longint'(HALF_PI_Q30)) begin
      z += longint'(PI_Q30); neg = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = shr(x, i); ys = shr(y, i); tab = longint'(atan_tab(i));
      if (z >= 0) begin
        x = x - ys; y = y + xs; z -= tab;
      end else begin
        x = x + ys; y = y - xs; z += tab;
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  function automatic longint clamp_q30(angle_t a, angle_t lo, angle_t hi);
    longint v;
    v = a;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v * (64'sd1 <<< (33 - ANGLE_WIDTH));
  endfunction

  function automatic coeff_t to_coeff(longint v);
    longint one;
    one = 64'sd1 <<< (COEFF_WIDTH - 2);
    v = shr(v + (64'sd1 <<< (FRAC_BITS - COEFF_WIDTH + 1)), FRAC_BITS - COEFF_WIDTH + 2);
    if (v > one) v = one;
    if (v < -one) v = -one;
    return coeff_t'(v);
  endfunction

  task automatic rotation_matrix(input pose_t p, output matrix_t m);
    longint sx, cx, sy, cy, sz, cz, czsy, szsy;
    sin_cos(clamp_q30(p.pose_x, limits[REG_X_MIN], limits[REG_X_MAX]), sx, cx);
    sin_cos(clamp_q30(p.pose_y, limits[REG_Y_MIN], limits[REG_Y_MAX]), sy, cy);
    sin_cos(clamp_q30(p.pose_z, limits[REG_Z_MIN], limits[REG_Z_MAX]), sz, cz);
    czsy = mulq(cz, sy);
    szsy = mulq(sz, sy);
    m.m_row0_col0 = to_coeff(mulq(cz, cy));
    m.m_row0_col1 = to_coeff(mulq(czsy, sx) - mulq(sz, cx));
    m.m_row0_col2 = to_coeff(mulq(czsy, cx) + mulq(sz, sx));
    m.m_row1_col0 = to_coeff(mulq(sz, cy));
    m.m_row1_col1 = to_coeff(mulq(szsy, sx) + mulq(cz, cx));
    m.m_row1_col2 = to_coeff(mulq(szsy, cx) - mulq(cz, sx));
    m.m_row2_col0 = to_coeff(-sy);
    m.m_row2_col1 = to_coeff(mulq(cy, sx));
    m.m_row2_col2 = to_coeff(mulq(cy, cx));
  endtask

  task automatic write_limit(input logic [IDX_WIDTH-1:0] idx, input angle_t val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    if (idx < NUM_REGS) limits[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_matrices.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic send_pose(input pose_t p);
    matrix_t m;
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rotation_matrix(p, m);
    pending_matrices = {pending_matrices, m};
    sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Request stream: consecutive sends keep valid high when there is no idle gap.
  task automatic send_burst(input int count);
    pose_t p;
    for (int i = 0; i < count; i++) begin
      p.pose_x = angle_t'($urandom);
      p.pose_y = angle_t'($urandom);
      p.pose_z = angle_t'($urandom);
      if ($urandom_range(3) == 0) p.pose_x = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      if ($urandom_range(3) == 0) p.pose_y = angle_t'($urandom_range(25736) - 12868);
      send_pose_fast(p);
    end
    in_valid <= 1'b0;
  endtask

  task automatic send_pose_fast(input pose_t p);
    matrix_t m;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(negedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rotation_matrix(p, m);
    pending_matrices = {pending_matrices, m};
    sent++;
    @(negedge clk);
  endtask

  always @(negedge clk)
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    matrix_t exp_m;
    if (rst_n && out_valid && !out_stall) begin
      received++;
      if (pending_matrices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_m = pending_matrices.pop_front();
        if (exp_m !== out_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", exp_m, out_data);
        end
      end
    end
  end

  typedef struct {
    pose_t p;
    bit known;
    matrix_t m;
  } row_t;

  localparam matrix_t IDENTITY = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
                                   16'sd0, 16'sd0, 16'sd0, 16'sd16384};

  initial begin
    row_t rows [$];
    pose_t p;
    matrix_t m;
    for (int i = 0; i < NUM_REGS; i += 2) begin
      limits[i] = 16'sh8000; limits[i+1] = 16'sh7FFF;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    rows = {rows, row_t'{'{16'sd0, 16'sd0, 16'sd0}, 1, IDENTITY}};
    rows = {rows, row_t'{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 0, '0}};
    rows = {rows, row_t'{'{16'sh8000, 16'sh8000, 16'sh8000}, 0, '0}};
    rows = {rows, row_t'{'{16'sd12868, 16'sd0, 16'sd0}, 0, '0}};
    rows = {rows, row_t'{'{16'sd0, 16'sd12868, 16'sd0}, 0, '0}};
    rows = {rows, row_t'{'{16'sd0, 16'sd0, -16'sd12868}, 0, '0}};
    rows = {rows, row_t'{'{16'sd25736, 16'sd25736, 16'sd25736}, 0, '0}};
    rows = {rows, row_t'{'{-16'sd25736, 16'sd12869, -16'sd12869}, 0, '0}};
    rows = {rows, row_t'{'{16'sh5555, 16'shAAAA, 16'sh0001}, 0, '0}};
    rows = {rows, row_t'{'{16'shFFFF, 16'sh0001, 16'shFFFF}, 0, '0}};
    foreach (rows[i]) begin
      send_pose(rows[i].p);
      if (rows[i].known) begin
        rotation_matrix(rows[i].p, m);
        if (m !== rows[i].m) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: expected %h predicted %h", i, rows[i].m, m);
        end
      end
    end
    drain();

    // Tight limits, an inverted pair, and out-of-range index.
    write_limit(REG_X_MIN, 16'sd0);
    write_limit(REG_X_MAX, 16'sd4000);
    write_limit(REG_Y_MIN, 16'sd5000);
    write_limit(REG_Y_MAX, -16'sd5000);
    write_limit(REG_Z_MIN, -16'sd100);
    write_limit(REG_Z_MAX, 16'sd100);
    write_limit(3'd6, 16'sd1);
    write_limit(3'd7, 16'sd1);
    rows.delete();
    rows = {rows, row_t'{'{16'sh8000, 16'sd0, 16'sd0}, 0, '0}};
    rows = {rows, row_t'{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 0, '0}};
    rows = {rows, row_t'{'{16'sd2000, 16'sh8000, 16'sd50}, 0, '0}};
    foreach (rows[i]) send_pose(rows[i].p);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      for (int r = 0; r < NUM_REGS; r++)
        write_limit(r[IDX_WIDTH-1:0], (phase == 4) ? ((r % 2) ? 16'sh7FFF : 16'sh8000)
                                                   : angle_t'($urandom));
      send_burst(95);
      while (pending_matrices.size() != 0) @(negedge clk);
      send_burst(95);
      drain();
    end
    idle_pct = 0; stall_pct = 0;
    repeat (5) @(negedge clk);

    $display("Sent %0d poses, %0d matrices checked, over 8 limit settings and 4 idling mixes.",
             sent, received);
    if (mismatches == 0 && pending_matrices.size() == 0)
      $display("PASS limited_euler_rotation_matrix_unit");
    else
      $display("FAIL limited_euler_rotation_matrix_unit");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL limited_euler_rotation_matrix_unit");
    $finish;
  end
endmodule
